// ----- src/fpalu_pkg.sv -----
package fpalu_pkg;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_MIN      = 4'd4,
    OP_MAX      = 4'd5,
    OP_CMP      = 4'd6,
    OP_INC      = 4'd7,
    OP_DEC      = 4'd8,
    OP_TO_INT   = 4'd9,
    OP_FROM_INT = 4'd10
  } op_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;

  typedef struct packed {
    logic [3:0]         req_type;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } req_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [1:0]         status;
    logic               is_less;
    logic               is_equal;
    logic               is_greater;
  } rsp_t;

  // Operation context carried along the divider chain
  typedef struct packed {
    logic        valid;
    logic [3:0]  op;
    logic        neg;
    logic        div0;
    logic [31:0] early;
    logic [1:0]  early_st;
    logic        lt;
    logic        eq;
    logic        gt;
  } ctx_t;

endpackage

// ----- src/fpalu_cell.sv -----
// One restoring-division step: shift in one numerator bit, trial subtract.
module fpalu_cell #(
  parameter int NW = 62
) (
  input  logic              clk,
  input  logic [NW-1:0]     num_in,
  input  logic [NW-1:0]     rem_in,
  input  logic [NW-1:0]     quo_in,
  input  logic [31:0]       den_in,
  input  fpalu_pkg::ctx_t   ctx_in,
  input  logic              rst,
  output logic [NW-1:0]     num_out,
  output logic [NW-1:0]     rem_out,
  output logic [NW-1:0]     quo_out,
  output logic [31:0]       den_out,
  output fpalu_pkg::ctx_t   ctx_out
);
  import fpalu_pkg::*;

  logic [NW:0] trial;
  logic [NW:0] diff;
  logic        take;

  // Trial subtract of the divisor from the shifted remainder
  always_comb begin
    trial = {rem_in, num_in[NW-1]};
    diff  = trial - {{(NW-31){1'b0}}, den_in};
    take  = (trial >= {{(NW-31){1'b0}}, den_in});
  end

  // Advance data to the next cell
  always_ff @(posedge clk) begin
    num_out <= num_in << 1;
    rem_out <= take ? diff[NW-1:0] : trial[NW-1:0];
    quo_out <= {quo_in[NW-2:0], take};
    den_out <= den_in;
  end

  // Advance the request context; only the valid bit is reset
  always_ff @(posedge clk) begin
    if (rst) begin
      ctx_out.valid <= 1'b0;
    end else begin
      ctx_out.valid <= ctx_in.valid;
    end
    ctx_out.op       <= ctx_in.op;
    ctx_out.neg      <= ctx_in.neg;
    ctx_out.div0     <= ctx_in.div0;
    ctx_out.early    <= ctx_in.early;
    ctx_out.early_st <= ctx_in.early_st;
    ctx_out.lt       <= ctx_in.lt;
    ctx_out.eq       <= ctx_in.eq;
    ctx_out.gt       <= ctx_in.gt;
  end

endmodule

// ----- src/fixed_point_alu.sv -----
// Signed fixed-point ALU, FRAC_BITS fraction bits on 32-bit words.
// Request channel: drive req (opcode, operand_a, operand_b) with start high;
// the request is taken at an edge where start is high and busy is low.
// busy is tied low: a new request may enter on every clock cycle.
// Response channel: rsp is valid for exactly one cycle while done is high.
// The receiver cannot stall; every response must be taken as it appears.
// Every opcode takes the same path: one input register stage for the
// multiply and operand conditioning, one cell per quotient bit of the
// divider chain (32 + FRAC_BITS cells), and one output stage for sign
// fixing, rounding and error checks.
// Throughput: one request per cycle, set by the fully pipelined cell row.
// Responses leave in request order.
// Reset (rst, synchronous) clears the valid bits in every stage, so no
// response appears after reset until a new request is taken.
// Status: 0 ok, 1 overflow, 2 divide by zero; value is zero on error.
// The less, equal and greater flags always compare operand_a with operand_b.
module fixed_point_alu #(
  parameter int FRAC_BITS = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  fpalu_pkg::req_t req,
  output logic            busy,
  output logic            done,
  output fpalu_pkg::rsp_t rsp
);
  import fpalu_pkg::*;

  localparam int NW    = 32 + FRAC_BITS;
  localparam int NCELL = NW;
  localparam int PW    = 64;

  logic take;
  assign busy = 1'b0;
  assign take = start & ~busy;

  // ---------- stage 0: multiply, compares, simple ops ----------
  logic signed [32:0] a_s, b_s;
  logic signed [33:0] sum_w, dif_w, inc_w, dec_w;
  logic signed [63:0] frm_w;
  logic signed [31:0] toi_w;
  logic        lt0, eq0, gt0;
  logic [31:0] early0;
  logic [1:0]  st0;

  always_comb begin
    a_s   = {req.operand_a[31], req.operand_a};
    b_s   = {req.operand_b[31], req.operand_b};
    sum_w = 34'(a_s) + 34'(b_s);
    dif_w = 34'(a_s) - 34'(b_s);
    inc_w = 34'(a_s) + 34'(signed'({1'b0, 33'(1) << FRAC_BITS}));
    dec_w = 34'(a_s) - 34'(signed'({1'b0, 33'(1) << FRAC_BITS}));
    frm_w = 64'(req.operand_a) <<< FRAC_BITS;
    toi_w = req.operand_a >>> FRAC_BITS;
    lt0   = req.operand_a < req.operand_b;
    eq0   = req.operand_a == req.operand_b;
    gt0   = req.operand_a > req.operand_b;
    early0 = '0;
    st0    = ST_OK;
    case (req.req_type)
      OP_ADD: begin
        if (sum_w[33:31] == 3'b000 || sum_w[33:31] == 3'b111) early0 = sum_w[31:0];
        else st0 = ST_OVF;
      end
      OP_SUB: begin
        if (dif_w[33:31] == 3'b000 || dif_w[33:31] == 3'b111) early0 = dif_w[31:0];
        else st0 = ST_OVF;
      end
      OP_INC: begin
        if (inc_w[33:31] == 3'b000 || inc_w[33:31] == 3'b111) early0 = inc_w[31:0];
        else st0 = ST_OVF;
      end
      OP_DEC: begin
        if (dec_w[33:31] == 3'b000 || dec_w[33:31] == 3'b111) early0 = dec_w[31:0];
        else st0 = ST_OVF;
      end
      OP_MIN:    early0 = lt0 ? req.operand_a : req.operand_b;
      OP_MAX:    early0 = gt0 ? req.operand_a : req.operand_b;
      OP_TO_INT: early0 = toi_w;
      OP_FROM_INT: begin
        if (frm_w[63:31] == '0 || frm_w[63:31] == '1) early0 = frm_w[31:0];
        else st0 = ST_OVF;
      end
      default: early0 = '0;
    endcase
  end

  // Divider operand magnitudes
  logic [31:0] mag_a, mag_b;
  assign mag_a = req.operand_a[31] ? 32'(-req.operand_a) : req.operand_a;
  assign mag_b = req.operand_b[31] ? 32'(-req.operand_b) : req.operand_b;

  // Register the request; multiply in this stage
  logic [NW-1:0] num1;
  logic [31:0]   den1;
  logic [PW-1:0] pmag1;
  ctx_t          ctx1;
  logic signed [63:0] prod;
  assign prod = 64'(req.operand_a) * 64'(req.operand_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctx1.valid <= 1'b0;
    end else begin
      ctx1.valid <= take;
    end
    num1     <= NW'(mag_a) << FRAC_BITS;
    den1     <= mag_b;
    pmag1    <= prod[63] ? 64'(-prod) : prod;
    ctx1.op  <= req.req_type;
    ctx1.neg <= (req.req_type == OP_MUL) ? prod[63]
                                         : (req.operand_a[31] ^ req.operand_b[31]);
    ctx1.div0     <= (req.operand_b == '0);
    ctx1.early    <= early0;
    ctx1.early_st <= st0;
    ctx1.lt <= lt0;
    ctx1.eq <= eq0;
    ctx1.gt <= gt0;
  end

  // ---------- division cell row ----------
  // The product magnitude rides along the row in a lane of its own, in step
  // with the cells, so that every opcode leaves after the same delay.
  logic [NW-1:0] num_c [NCELL+1];
  logic [NW-1:0] rem_c [NCELL+1];
  logic [NW-1:0] quo_c [NCELL+1];
  logic [31:0]   den_c [NCELL+1];
  ctx_t          ctx_c [NCELL+1];
  logic [PW-1:0] pm_c  [NCELL+1];

  assign num_c[0] = num1;
  assign rem_c[0] = '0;
  assign quo_c[0] = '0;
  assign den_c[0] = den1;
  assign ctx_c[0] = ctx1;
  assign pm_c[0]  = pmag1;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    fpalu_cell #(.NW(NW)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .num_in (num_c[i]),
      .rem_in (rem_c[i]),
      .quo_in (quo_c[i]),
      .den_in (den_c[i]),
      .ctx_in (ctx_c[i]),
      .num_out(num_c[i+1]),
      .rem_out(rem_c[i+1]),
      .quo_out(quo_c[i+1]),
      .den_out(den_c[i+1]),
      .ctx_out(ctx_c[i+1])
    );
    always_ff @(posedge clk) begin
      pm_c[i+1] <= pm_c[i];
    end
  end

  // ---------- output stage ----------
  ctx_t          ce;
  logic [NW-1:0] q;
  logic [PW-1:0] pm, pr;
  logic [64:0]   qm;
  logic [31:0]   val;
  logic [1:0]    st;

  assign ce = ctx_c[NCELL];
  assign q  = quo_c[NCELL];
  assign pm = pm_c[NCELL];

  always_comb begin
    pr  = (FRAC_BITS > 0) ? ((pm + (64'(1) << (FRAC_BITS - 1))) >> FRAC_BITS) : pm;
    qm  = '0;
    val = ce.early;
    st  = ce.early_st;
    case (ce.op)
      OP_MUL: begin
        qm = 65'(pr);
        val = '0;
      end
      OP_DIV: begin
        qm = 65'(q);
        val = '0;
      end
      default: qm = '0;
    endcase
    if (ce.op == OP_MUL || (ce.op == OP_DIV && !ce.div0)) begin
      if (ce.neg ? (qm > 65'h80000000) : (qm > 65'h7FFFFFFF)) st = ST_OVF;
      else val = ce.neg ? 32'(-qm[31:0]) : qm[31:0];
    end else if (ce.op == OP_DIV) begin
      st = ST_DIV0;
    end
    if (st != ST_OK) val = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ce.valid;
    end
  end

  always_ff @(posedge clk) begin
    rsp.result_value <= val;
    rsp.status       <= st;
    rsp.is_less      <= ce.lt;
    rsp.is_equal     <= ce.eq;
    rsp.is_greater   <= ce.gt;
  end

  // ---------- assertions ----------
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    done && rsp.status != ST_OK |-> rsp.result_value == '0)
    else $error("nonzero value on error");
  a_flags_onehot: assert property (@(posedge clk) disable iff (rst)
    done |-> $onehot({rsp.is_less, rsp.is_equal, rsp.is_greater}))
    else $error("compare flags not one-hot");
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> rsp.status != 2'd3)
    else $error("bad status code");
  a_row_valid: assert property (@(posedge clk) disable iff (rst)
    ce.valid |=> done)
    else $error("response lost at output stage");

endmodule

// ----- bench/tb_fixed_point_alu.sv -----
`timescale 1ns / 1ps

module tb_fixed_point_alu;
  import fpalu_pkg::*;

  localparam int FRAC = 8;
  localparam int LATENCY = 32 + FRAC + 2;
  localparam int IDLE_LIMIT = 2000;

  // Work out one response from one request
  function automatic rsp_t alu_predict(req_t rq);
    rsp_t r;
    logic signed [63:0] a, b, wide, prod;
    logic [63:0] mag, quo;
    logic neg, ok;
    logic [1:0] st;
    a = rq.operand_a;
    b = rq.operand_b;
    wide = 0;
    ok = 1'b1;
    st = ST_OK;
    case (rq.req_type)
      OP_ADD: begin
        wide = a + b;
      end
      OP_SUB: begin
        wide = a - b;
      end
      OP_MUL: begin
        prod = a * b;
        neg = prod < 0;
        mag = neg ? -prod : prod;
        mag = (mag + (64'd1 << (FRAC - 1))) >> FRAC;
        wide = neg ? -$signed(mag) : $signed(mag);
        if (neg ? mag > 64'h8000_0000 : mag > 64'h7fff_ffff) ok = 1'b0;
      end
      OP_DIV: begin
        if (b == 0) begin
          st = ST_DIV0;
        end else begin
          mag = (a < 0 ? -a : a);
          mag = mag << FRAC;
          quo = mag / (b < 0 ? -b : b);
          neg = (a < 0) != (b < 0);
          wide = neg ? -$signed(quo) : $signed(quo);
          if (neg ? quo > 64'h8000_0000 : quo > 64'h7fff_ffff) ok = 1'b0;
        end
      end
      OP_MIN: wide = a < b ? a : b;
      OP_MAX: wide = a > b ? a : b;
      OP_INC: wide = a + (64'sd1 <<< FRAC);
      OP_DEC: wide = a - (64'sd1 <<< FRAC);
      OP_TO_INT: wide = a >>> FRAC;
      OP_FROM_INT: wide = a <<< FRAC;
      default: wide = 0;
    endcase
    if (rq.req_type inside {OP_ADD, OP_SUB, OP_INC, OP_DEC, OP_FROM_INT})
      if (wide > 64'sd2147483647 || wide < -64'sd2147483648) ok = 1'b0;
    if (!ok) st = ST_OVF;
    r.result_value = (st == ST_OK) ? wide[31:0] : 32'd0;
    r.status = st;
    r.is_less = a < b;
    r.is_equal = a == b;
    r.is_greater = a > b;
    return r;
  endfunction

  class alu_scoreboard;
    rsp_t pending[$];
    int mismatches;
    int checked;

    function void note_request(req_t rq);
      pending.push_back(alu_predict(rq));
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %p", got);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("response %0d: expected %p, got %p", checked, want, got);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  req_t req = '0;
  logic busy;
  logic done;
  rsp_t rsp;
  alu_scoreboard board;
  int idle_cycles;
  int sent;

  fixed_point_alu #(.FRAC_BITS(FRAC)) u_dut (
    .clk(clk), .rst(rst), .start(start), .req(req),
    .busy(busy), .done(done), .rsp(rsp)
  );

  always #5 clk = ~clk;

  // Check responses and watch for a stall
  always @(posedge clk) begin
    if (!rst) begin
      if (done) board.check_response(rsp);
      if (done || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'd0;
      3: return 32'hffff_ffff;
      4: return $urandom_range(0, 2047) - 1024;
      5: return {{8{1'b0}}, 24'($urandom)} ^ {32{$urandom_range(0, 1) == 1}};
      default: return $urandom;
    endcase
  endfunction

  // Hold a request until taken, after a random gap when gap is set
  task automatic send_request(logic [3:0] op, logic [31:0] a, logic [31:0] b, bit gap);
    req_t rq;
    int wait_n;
    wait_n = gap ? $urandom_range(0, 14) : 0;
    if ($urandom_range(0, 3) == 0) wait_n = 0;
    if (wait_n > 0) begin
      start <= 1'b0;
      repeat (wait_n) @(posedge clk);
    end
    rq.req_type = op;
    rq.operand_a = a;
    rq.operand_b = b;
    req <= rq;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_request(rq);
    sent++;
  endtask

  initial begin
    int n;
    logic [31:0] a, b;
    board = new();
    idle_cycles = 0;
    sent = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes and special cases
    send_request(OP_ADD, 32'h7fff_ffff, 32'd1, 0);
    send_request(OP_SUB, 32'h8000_0000, 32'd1, 0);
    send_request(OP_MUL, 32'h8000_0000, 32'h8000_0000, 0);
    send_request(OP_MUL, 32'h0000_0180, 32'hffff_ff80, 0);
    send_request(OP_MUL, 32'h0000_0080, 32'h0000_0001, 0);
    send_request(OP_DIV, 32'h1234_5678, 32'd0, 0);
    send_request(OP_DIV, 32'h8000_0000, 32'hffff_ffff, 0);
    send_request(OP_DIV, 32'hffff_fd00, 32'h0000_0700, 0);
    send_request(OP_MIN, 32'h8000_0000, 32'h7fff_ffff, 0);
    send_request(OP_MAX, 32'h8000_0000, 32'h7fff_ffff, 0);
    send_request(OP_MIN, 32'd5, 32'd5, 0);
    send_request(OP_CMP, 32'hffff_ffff, 32'd0, 0);
    send_request(OP_INC, 32'h7fff_ff00, 32'd0, 0);
    send_request(OP_DEC, 32'h8000_00ff, 32'd0, 0);
    send_request(OP_TO_INT, 32'hffff_ff01, 32'd0, 0);
    send_request(OP_TO_INT, 32'h7fff_ffff, 32'd0, 0);
    send_request(OP_FROM_INT, 32'h0080_0000, 32'd0, 0);
    send_request(OP_FROM_INT, 32'hff80_0000, 32'd0, 0);
    send_request(4'd11, 32'd1, 32'd2, 0);
    send_request(4'd15, 32'hffff_ffff, 32'hffff_ffff, 0);

    // Random requests, mostly legal opcodes
    for (n = 0; n < 600; n++) begin
      a = pick_word();
      b = ($urandom_range(0, 5) == 0) ? a : pick_word();
      send_request(($urandom_range(0, 9) == 0) ? 4'($urandom_range(11, 15))
                   : 4'($urandom_range(0, 10)), a, b, n % 100 >= 30);
    end
    start <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    $display("Sent %0d requests over all opcodes; %0d responses checked.",
             sent, board.checked);
    if (board.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
src/fpalu_pkg.sv
src/fpalu_cell.sv
src/fixed_point_alu.sv
bench/tb_fixed_point_alu.sv
